// ===== rtl/tas_pkg.sv =====
package tas_pkg;

    localparam int COORD_W      = 24;
    localparam int TEXEL_ADDR_W = 12;
    localparam int TEXEL_W      = 32;
    localparam int SIZE_REG_W   = 7;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 5;
    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_WRITE  = 1'b1
    } req_kind_t;

    typedef enum logic [1:0]
    {
        MODE_CLAMP  = 2'd0,
        MODE_WRAP   = 2'd1,
        MODE_MIRROR = 2'd2,
        MODE_BORDER = 2'd3
    } addr_mode_t;

    typedef enum logic [2:0]
    {
        REG_TEX_WIDTH   = 3'd0,
        REG_TEX_HEIGHT  = 3'd1,
        REG_U_MODE      = 3'd2,
        REG_V_MODE      = 3'd3,
        REG_BORDER_RGBA = 3'd4
    } cfg_reg_t;

    typedef struct packed
    {
        req_kind_t                  req_type;
        logic signed [COORD_W-1:0]  s_coord;
        logic signed [COORD_W-1:0]  t_coord;
        logic [TEXEL_ADDR_W-1:0]    texel_addr;
        logic [TEXEL_W-1:0]         texel_value;
    } req_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       used_border;
    } rsp_t;

endpackage

// ===== rtl/tas_queue.sv =====
module tas_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int DEPTH = tas_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/tas_front.sv =====
module tas_front #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 16,
    parameter int DIM_W     = $clog2(MAX_DIM + 1),
    parameter int XW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int QW        = 2 + 2 * XW + tas_pkg::TEXEL_ADDR_W + tas_pkg::TEXEL_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tas_pkg::req_t        req,
    input  tas_pkg::addr_mode_t  u_mode,
    input  tas_pkg::addr_mode_t  v_mode,
    input  logic [DIM_W-1:0]     tex_w,
    input  logic [DIM_W-1:0]     tex_h,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [QW-1:0]        q_data
);

    localparam int COORD_W = tas_pkg::COORD_W;
    localparam int R_W     = (COORD_W > FRAC_BITS + 2) ? COORD_W : FRAC_BITS + 2;
    localparam int PW      = R_W + DIM_W;
    localparam logic [R_W-1:0] ONE_FX    = R_W'(1) << FRAC_BITS;
    localparam logic [R_W-1:0] TWO_FX    = ONE_FX << 1;
    localparam logic [R_W-1:0] FRAC_MASK = ONE_FX - R_W'(1);
    localparam logic [R_W-1:0] MIR_MASK  = TWO_FX - R_W'(1);

    // {border hit, reduced nonnegative coordinate}
    function automatic logic [R_W:0] reduce_coord(
        input logic [COORD_W-1:0] c,
        input tas_pkg::addr_mode_t mode
    );
        logic           neg;
        logic           hit;
        logic [R_W-1:0] cs;
        logic [R_W-1:0] mag;
        logic [R_W-1:0] m;
        logic [R_W-1:0] r;
        neg = c[COORD_W-1];
        cs  = R_W'(signed'(c));
        mag = neg ? (~cs + R_W'(1)) : cs;
        m   = mag & MIR_MASK;
        hit = 1'b0;
        r   = '0;
        unique case (mode)
            tas_pkg::MODE_CLAMP:  r = neg ? '0 : cs;
            tas_pkg::MODE_WRAP:   r = cs & FRAC_MASK;
            tas_pkg::MODE_MIRROR: r = (m > ONE_FX) ? (TWO_FX - m) : m;
            tas_pkg::MODE_BORDER:
            begin
                hit = neg || (cs >= ONE_FX);
                r   = cs;
            end
            default: r = '0;
        endcase
        return {hit, r};
    endfunction

    logic                              f1_valid_reg, f1_valid_next;
    tas_pkg::req_kind_t                f1_kind_reg;
    logic                              f1_hit_reg;
    logic [R_W-1:0]                    f1_ru_reg;
    logic [R_W-1:0]                    f1_rv_reg;
    logic [tas_pkg::TEXEL_ADDR_W-1:0]  f1_waddr_reg;
    logic [tas_pkg::TEXEL_W-1:0]       f1_wval_reg;

    logic           accept;
    logic [R_W:0]   red_u, red_v;
    logic [PW-1:0]  prod_u, prod_v, pu, pv;
    logic [XW-1:0]  x_idx, y_idx;

    assign full   = f1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = f1_valid_reg && !q_full;

    assign red_u = reduce_coord(req.s_coord, u_mode);
    assign red_v = reduce_coord(req.t_coord, v_mode);

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
        begin
            f1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_kind_reg  <= req.req_type;
            f1_hit_reg   <= red_u[R_W] || red_v[R_W];
            f1_ru_reg    <= red_u[R_W-1:0];
            f1_rv_reg    <= red_v[R_W-1:0];
            f1_waddr_reg <= req.texel_addr;
            f1_wval_reg  <= req.texel_value;
        end
    end

    // scale to texels, drop the fraction, clamp to size-1
    assign prod_u = PW'(f1_ru_reg) * PW'(tex_w);
    assign prod_v = PW'(f1_rv_reg) * PW'(tex_h);
    assign pu     = prod_u >> FRAC_BITS;
    assign pv     = prod_v >> FRAC_BITS;
    assign x_idx  = (pu >= PW'(tex_w)) ? XW'(tex_w - DIM_W'(1)) : XW'(pu);
    assign y_idx  = (pv >= PW'(tex_h)) ? XW'(tex_h - DIM_W'(1)) : XW'(pv);

    assign q_data = {f1_kind_reg, f1_hit_reg, x_idx, y_idx, f1_waddr_reg, f1_wval_reg};

endmodule

// ===== rtl/tas_back.sv =====
module tas_back #(
    parameter int MAX_DIM = 64,
    parameter int TEXELS  = 4096,
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int XW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int QW      = 2 + 2 * XW + tas_pkg::TEXEL_ADDR_W + tas_pkg::TEXEL_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic [QW-1:0]                q_data,
    output logic                         q_pop,
    input  logic [DIM_W-1:0]             tex_w,
    input  logic [tas_pkg::TEXEL_W-1:0]  border_rgba,
    output logic                         empty,
    input  logic                         pop,
    output tas_pkg::rsp_t                rsp
);

    localparam int TW  = tas_pkg::TEXEL_W;
    localparam int TAW = tas_pkg::TEXEL_ADDR_W;
    localparam int YWW = XW + DIM_W;
    localparam int SW  = YWW + 1;
    localparam int AW  = (TEXELS > 1) ? $clog2(TEXELS) : 1;

    tas_pkg::req_kind_t  q_kind;
    logic                q_hit;
    logic [XW-1:0]       q_x, q_y;
    logic [TAW-1:0]      q_waddr;
    logic [TW-1:0]       q_wval;

    logic                m_valid_reg, m_valid_next;
    tas_pkg::req_kind_t  m_kind_reg;
    logic                m_hit_reg;
    logic [XW-1:0]       m_x_reg;
    logic [YWW-1:0]      m_yw_reg;
    logic [TAW-1:0]      m_waddr_reg;
    logic [TW-1:0]       m_wval_reg;

    logic                o_valid_reg, o_valid_next;
    logic                o_hit_reg;
    logic                o_oob_reg;
    logic [TW-1:0]       rd_reg;

    logic [TW-1:0]       texel_mem [TEXELS];

    logic                o_ready, m_ready, m_is_write, m_adv_sample;
    logic [SW-1:0]       s_addr;
    logic                s_in, w_in;
    logic [AW-1:0]       acc_idx;
    logic                mem_we, mem_re;
    logic [TW-1:0]       px;

    assign q_kind  = tas_pkg::req_kind_t'(q_data[QW-1]);
    assign q_hit   = q_data[QW-2];
    assign q_x     = q_data[QW-3 -: XW];
    assign q_y     = q_data[QW-3-XW -: XW];
    assign q_waddr = q_data[TW +: TAW];
    assign q_wval  = q_data[TW-1:0];

    // a write never occupies the output stage
    assign m_is_write   = (m_kind_reg == tas_pkg::REQ_WRITE);
    assign o_ready      = !o_valid_reg || pop;
    assign m_ready      = !m_valid_reg || m_is_write || o_ready;
    assign q_pop        = !q_empty && m_ready;
    assign m_adv_sample = m_valid_reg && !m_is_write && o_ready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_ready)
        begin
            m_valid_next = q_pop;
        end
        o_valid_next = o_valid_reg;
        if (m_adv_sample)
        begin
            o_valid_next = 1'b1;
        end
        else if (pop)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_kind_reg  <= q_kind;
            m_hit_reg   <= q_hit;
            m_x_reg     <= q_x;
            m_yw_reg    <= YWW'(q_y) * YWW'(tex_w);
            m_waddr_reg <= q_waddr;
            m_wval_reg  <= q_wval;
        end
        if (m_adv_sample)
        begin
            o_hit_reg <= m_hit_reg;
            o_oob_reg <= !s_in;
        end
    end

    assign s_addr  = SW'(m_x_reg) + SW'(m_yw_reg);
    assign s_in    = (32'(s_addr) < 32'(TEXELS));
    assign w_in    = (32'(m_waddr_reg) < 32'(TEXELS));
    assign acc_idx = m_is_write ? AW'(m_waddr_reg) : AW'(s_addr);
    assign mem_we  = m_valid_reg && m_is_write && w_in;
    assign mem_re  = m_adv_sample && !m_hit_reg && s_in;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            texel_mem[acc_idx] <= m_wval_reg;
        end
        if (mem_re)
        begin
            rd_reg <= texel_mem[acc_idx];
        end
    end

    assign empty = !o_valid_reg;
    assign px    = o_hit_reg ? border_rgba : (o_oob_reg ? '0 : rd_reg);

    assign rsp.red         = px[31:24];
    assign rsp.green       = px[23:16];
    assign rsp.blue        = px[15:8];
    assign rsp.alpha       = px[7:0];
    assign rsp.used_border = o_hit_reg;

endmodule

// ===== rtl/texture_address_sampler_unit.sv =====
// Nearest-texel texture sampler. Push a beat with req_type = write to load one RGBA texel
// (red in 31:24) at texel_addr = x + y*width; writes at or past TEXELS are dropped and give
// no result. Push a beat with req_type = sample and signed Q8.16 s/t coordinates to get one
// result beat: each axis maps its coordinate by its own mode (clamp, wrap, mirror or border),
// the index is clamped to size-1 and the texel at x + y*width comes back as four bytes. A
// border hit on either axis returns border_rgba with used_border set; an index past the store
// returns zero. Results leave in order through the empty/pop side. The block sustains one beat
// per clock when results are taken as fast as they come; the single-port texel memory carries
// at most one write or one read per clock, which sets that figure. A sample result passes from
// the front register through the queue and the multiply stage to the memory read register. The
// front and back halves are parted by a four-entry queue, so the input keeps taking beats while
// results wait. Texels read before they were ever written are undefined. Registers must be
// written over APB only while the block is idle, by the user; the block itself does not enforce
// this, and there is no clearing pass after reset.
module texture_address_sampler_unit #(
    parameter int MAX_DIM   = 64,
    parameter int TEXELS    = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tas_pkg::PADDR_W-1:0]   paddr,
    input  logic [tas_pkg::DATA_W-1:0]    pwdata,
    output logic [tas_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  tas_pkg::req_t                 req,
    output logic                          empty,
    input  logic                          pop,
    output tas_pkg::rsp_t                 rsp
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int XW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int QW    = 2 + 2 * XW + tas_pkg::TEXEL_ADDR_W + tas_pkg::TEXEL_W;
    localparam int SRW   = tas_pkg::SIZE_REG_W;

    // configuration registers
    logic [SRW-1:0]        tex_width_reg, tex_width_next;
    logic [SRW-1:0]        tex_height_reg, tex_height_next;
    tas_pkg::addr_mode_t   u_mode_reg, u_mode_next;
    tas_pkg::addr_mode_t   v_mode_reg, v_mode_next;
    logic [31:0]           border_rgba_reg, border_rgba_next;

    tas_pkg::cfg_reg_t     cfg_sel;
    logic                  cfg_we;
    logic [DIM_W-1:0]      eff_w, eff_h;

    logic                  q_push, q_full, q_pop, q_empty;
    logic [QW-1:0]         q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign cfg_sel = tas_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        tex_width_next   = tex_width_reg;
        tex_height_next  = tex_height_reg;
        u_mode_next      = u_mode_reg;
        v_mode_next      = v_mode_reg;
        border_rgba_next = border_rgba_reg;
        if (cfg_we)
        begin
            unique case (cfg_sel)
                tas_pkg::REG_TEX_WIDTH:   tex_width_next   = pwdata[SRW-1:0];
                tas_pkg::REG_TEX_HEIGHT:  tex_height_next  = pwdata[SRW-1:0];
                tas_pkg::REG_U_MODE:      u_mode_next      = tas_pkg::addr_mode_t'(pwdata[1:0]);
                tas_pkg::REG_V_MODE:      v_mode_next      = tas_pkg::addr_mode_t'(pwdata[1:0]);
                tas_pkg::REG_BORDER_RGBA: border_rgba_next = pwdata;
                default:                  ; // drop writes past the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            tas_pkg::REG_TEX_WIDTH:   prdata = 32'(tex_width_reg);
            tas_pkg::REG_TEX_HEIGHT:  prdata = 32'(tex_height_reg);
            tas_pkg::REG_U_MODE:      prdata = 32'(u_mode_reg);
            tas_pkg::REG_V_MODE:      prdata = 32'(v_mode_reg);
            tas_pkg::REG_BORDER_RGBA: prdata = border_rgba_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg   <= SRW'(2);
            tex_height_reg  <= SRW'(2);
            u_mode_reg      <= tas_pkg::MODE_WRAP;
            v_mode_reg      <= tas_pkg::MODE_WRAP;
            border_rgba_reg <= 32'h0000_00FF;
        end
        else
        begin
            tex_width_reg   <= tex_width_next;
            tex_height_reg  <= tex_height_next;
            u_mode_reg      <= u_mode_next;
            v_mode_reg      <= v_mode_next;
            border_rgba_reg <= border_rgba_next;
        end
    end

    // A size of zero acts as one; a size above MAX_DIM acts as MAX_DIM.
    always_comb
    begin
        if (tex_width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if (32'(tex_width_reg) > 32'(MAX_DIM))
        begin
            eff_w = DIM_W'(MAX_DIM);
        end
        else
        begin
            eff_w = DIM_W'(tex_width_reg);
        end
        if (tex_height_reg == '0)
        begin
            eff_h = DIM_W'(1);
        end
        else if (32'(tex_height_reg) > 32'(MAX_DIM))
        begin
            eff_h = DIM_W'(MAX_DIM);
        end
        else
        begin
            eff_h = DIM_W'(tex_height_reg);
        end
    end

    // Front: take the beat, reduce each coordinate by its mode, scale and clamp to an index.
    tas_front #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .DIM_W     (DIM_W),
        .XW        (XW),
        .QW        (QW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .req    (req),
        .u_mode (u_mode_reg),
        .v_mode (v_mode_reg),
        .tex_w  (eff_w),
        .tex_h  (eff_h),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // Decoupling queue between index generation and texel access.
    tas_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: form the linear address, write or read the texel store, hold the result beat.
    tas_back #(
        .MAX_DIM (MAX_DIM),
        .TEXELS  (TEXELS),
        .DIM_W   (DIM_W),
        .XW      (XW),
        .QW      (QW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .tex_w       (eff_w),
        .border_rgba (border_rgba_reg),
        .empty       (empty),
        .pop         (pop),
        .rsp         (rsp)
    );

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back popped an empty queue");

    // With the queue not draining, a full front stays full.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_pop) |=> full)
        else $error("front lost a held beat while the queue was stalled");

endmodule
